[design/wsdf_pkg.sv]
// shared types and constants for the websocket frame deframer
package wsdf_pkg;

    localparam int unsigned LEN_W  = 17;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned OP_W   = 4;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 17'h10000;

    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    localparam logic [OP_W-1:0] OP_TEXT   = 4'd1;
    localparam logic [OP_W-1:0] OP_BINARY = 4'd2;
    localparam logic [OP_W-1:0] OP_CLOSE  = 4'd8;
    localparam logic [OP_W-1:0] OP_PING   = 4'd9;
    localparam logic [OP_W-1:0] OP_PONG   = 4'd10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [OP_W-1:0]   opcode;
        logic              frame_end;
    } res_t;

endpackage

[design/wsdf_if.sv]
// stream and configuration interfaces of the websocket frame deframer
interface wsdf_byte_if;
    logic                       valid;
    logic                       ready;
    logic [wsdf_pkg::BYTE_W-1:0] wire_byte;

    modport source (output valid, output wire_byte, input ready);
    modport sink (input valid, input wire_byte, output ready);
endinterface

interface wsdf_res_if;
    logic                        valid;
    logic                        ready;
    logic [wsdf_pkg::KIND_W-1:0] kind;
    logic [wsdf_pkg::BYTE_W-1:0] data;
    logic [wsdf_pkg::OP_W-1:0]   opcode;
    logic                        frame_end;

    modport source (output valid, output kind, output data, output opcode,
                    output frame_end, input ready);
    modport sink (input valid, input kind, input data, input opcode,
                  input frame_end, output ready);
endinterface

interface wsdf_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [wsdf_pkg::LEN_W-1:0] max_payload;

    modport source (output valid, output max_payload, input ready);
    modport sink (input valid, input max_payload, output ready);
endinterface

[design/wsdf_out_reg.sv]
// result register with valid/ready hold toward the consumer
module wsdf_out_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  wsdf_pkg::res_t  din,
    output logic            free,
    wsdf_res_if.source      res
);

    logic           valid_reg;
    wsdf_pkg::res_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign free          = !valid_reg || res.ready;
    assign res.valid     = valid_reg;
    assign res.kind      = data_reg.kind;
    assign res.data      = data_reg.data;
    assign res.opcode    = data_reg.opcode;
    assign res.frame_end = data_reg.frame_end;

endmodule

[design/websocket_client_frame_deframer_core.sv]
// Client-to-server websocket frame deframer: takes one wire byte per clock
// transaction, parses the two header bytes, the 16- or 64-bit extended length and
// the 4-byte mask key, and returns each payload byte unmasked with its opcode and
// an end-of-frame flag; a zero-length frame returns one empty-frame result. A byte
// goes through an input register, then one state update whose result lands in the
// output register, and one byte is taken every cycle while the consumer keeps
// taking results. A protocol error returns one error result, after which bytes
// are still taken but give nothing until reset. max_payload is written through
// the cfg channel, which is always ready; the user must write it only while no
// byte is in flight, and the block itself does not enforce this.
module websocket_client_frame_deframer_core
(
    input  logic       clk,
    input  logic       rst_n,
    wsdf_byte_if.sink  rx,
    wsdf_res_if.source res,
    wsdf_cfg_if.sink   cfg
);

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_HALT    = 6'b100000
    } phase_t;

    localparam int unsigned LW = wsdf_pkg::LEN_W;

    function automatic logic len_bad(input logic [LW-1:0] acc, input logic high,
                                     input logic [6:0] code, input logic [LW-1:0] maxp);
        logic bad;
        bad = high;
        if (code == 7'd126 && acc < 17'd126)
        begin
            bad = 1'b1;
        end
        if (code == 7'd127 && acc < 17'h10000)
        begin
            bad = 1'b1;
        end
        if (acc > maxp)
        begin
            bad = 1'b1;
        end
        return bad;
    endfunction

    logic [LW-1:0] max_payload_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       go;
    logic       out_free;

    phase_t     phase_reg, phase_next;
    logic [3:0] hdr_flags_reg, hdr_flags_next;
    logic [3:0] opcode_reg, opcode_next;
    logic [6:0] code_reg, code_next;
    logic [3:0] step_reg, step_next;
    logic [LW-1:0] acc_reg, acc_next;
    logic       high_reg, high_next;
    logic [31:0] key_reg, key_next;
    logic [LW-1:0] left_reg, left_next;
    logic [1:0] idx_reg, idx_next;

    logic           emit;
    wsdf_pkg::res_t res_d;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= wsdf_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg.valid)
        begin
            max_payload_reg <= cfg.max_payload;
        end
    end

    // input register
    assign go       = in_valid_reg && out_free;
    assign rx.ready = !in_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.wire_byte;
        end
    end

    // frame parser
    always_comb
    begin
        logic [7:0]  b;
        logic [24:0] t;
        logic [3:0]  need;
        logic        hdr_bad;
        logic        done_len;
        logic [LW-1:0] len_v;
        logic        high_v;
        logic [7:0]  kb;

        b        = in_byte_reg;
        t        = {acc_reg, b};
        need     = (code_reg == 7'd126) ? 4'd2 : 4'd8;
        hdr_bad  = 1'b0;
        done_len = 1'b0;
        len_v    = acc_reg;
        high_v   = high_reg;
        kb       = key_reg[31:24];

        phase_next     = phase_reg;
        hdr_flags_next = hdr_flags_reg;
        opcode_next    = opcode_reg;
        code_next      = code_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        high_next      = high_reg;
        key_next       = key_reg;
        left_next      = left_reg;
        idx_next       = idx_reg;

        emit            = 1'b0;
        res_d.kind      = wsdf_pkg::KIND_BYTE;
        res_d.data      = 8'd0;
        res_d.opcode    = opcode_reg;
        res_d.frame_end = 1'b0;

        if (go)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    hdr_flags_next = b[7:4];
                    opcode_next    = b[3:0];
                    phase_next     = PH_HDR1;
                end
                PH_HDR1:
                begin
                    code_next = b[6:0];
                    hdr_bad = !(opcode_reg == wsdf_pkg::OP_TEXT
                                || opcode_reg == wsdf_pkg::OP_BINARY
                                || opcode_reg == wsdf_pkg::OP_CLOSE
                                || opcode_reg == wsdf_pkg::OP_PING
                                || opcode_reg == wsdf_pkg::OP_PONG)
                              || !hdr_flags_reg[3] || (hdr_flags_reg[2:0] != 3'd0)
                              || !b[7] || (opcode_reg[3] && b[6:0] > 7'd125)
                              || (opcode_reg == wsdf_pkg::OP_CLOSE && b[6:0] == 7'd1);
                    if (!hdr_bad)
                    begin
                        acc_next  = '0;
                        high_next = 1'b0;
                        step_next = 4'd0;
                        if (b[6:0] < 7'd126)
                        begin
                            len_v    = {{(LW-7){1'b0}}, b[6:0]};
                            high_v   = 1'b0;
                            acc_next = len_v;
                            done_len = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_EXTLEN;
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    len_v     = t[LW-1:0];
                    high_v    = high_reg | (|t[24:LW]);
                    acc_next  = len_v;
                    high_next = high_v;
                    step_next = step_reg + 4'd1;
                    if (step_next >= need)
                    begin
                        done_len = 1'b1;
                    end
                end
                PH_MASK:
                begin
                    key_next  = {key_reg[23:0], b};
                    step_next = step_reg + 4'd1;
                    if (step_next >= 4'd4)
                    begin
                        step_next = 4'd0;
                        idx_next  = 2'd0;
                        if (left_reg == '0)
                        begin
                            emit            = 1'b1;
                            res_d.kind      = wsdf_pkg::KIND_EMPTY;
                            res_d.frame_end = 1'b1;
                            phase_next      = PH_HDR0;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    case (idx_reg)
                        2'd0: kb = key_reg[31:24];
                        2'd1: kb = key_reg[23:16];
                        2'd2: kb = key_reg[15:8];
                        default: kb = key_reg[7:0];
                    endcase
                    emit            = 1'b1;
                    res_d.kind      = wsdf_pkg::KIND_BYTE;
                    res_d.data      = b ^ kb;
                    res_d.frame_end = (left_reg <= 17'd1);
                    idx_next        = idx_reg + 2'd1;
                    left_next       = left_reg - 17'd1;
                    if (left_reg <= 17'd1)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                PH_HALT:
                begin
                    phase_next = PH_HALT;
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase

            if (done_len)
            begin
                if (len_bad(len_v, high_v, code_next, max_payload_reg))
                begin
                    hdr_bad = 1'b1;
                end
                else
                begin
                    left_next  = len_v;
                    step_next  = 4'd0;
                    key_next   = '0;
                    phase_next = PH_MASK;
                end
            end

            if (hdr_bad)
            begin
                emit            = 1'b1;
                res_d.kind      = wsdf_pkg::KIND_ERROR;
                res_d.data      = 8'd0;
                res_d.frame_end = 1'b0;
                phase_next      = PH_HALT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            hdr_flags_reg <= 4'd0;
            opcode_reg    <= 4'd0;
            code_reg      <= 7'd0;
            step_reg      <= 4'd0;
            acc_reg       <= '0;
            high_reg      <= 1'b0;
            key_reg       <= 32'd0;
            left_reg      <= '0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_flags_reg <= hdr_flags_next;
            opcode_reg    <= opcode_next;
            code_reg      <= code_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            high_reg      <= high_next;
            key_reg       <= key_next;
            left_reg      <= left_next;
            idx_reg       <= idx_next;
        end
    end

    wsdf_out_reg u_out_reg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (emit),
        .din   (res_d),
        .free  (out_free),
        .res   (res)
    );

endmodule

[design/wsdf_checker.sv]
// port-level checks for the websocket frame deframer, bound to the top level
module wsdf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] res_kind,
    input logic [7:0] res_data,
    input logic [3:0] res_opcode,
    input logic       res_frame_end
);

    // no result right after an error transaction: the block is halted
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_kind == wsdf_pkg::KIND_ERROR |=> !res_valid)
        else $error("result after protocol error");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != wsdf_pkg::KIND_BYTE |-> res_data == 8'd0)
        else $error("nonzero data on non-byte result");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_kind == wsdf_pkg::KIND_EMPTY && res_frame_end)
                   || (res_kind == wsdf_pkg::KIND_ERROR && !res_frame_end)
                   || res_kind == wsdf_pkg::KIND_BYTE)
        else $error("bad kind or frame_end");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != wsdf_pkg::KIND_ERROR |->
            res_opcode == wsdf_pkg::OP_TEXT || res_opcode == wsdf_pkg::OP_BINARY
            || res_opcode == wsdf_pkg::OP_CLOSE || res_opcode == wsdf_pkg::OP_PING
            || res_opcode == wsdf_pkg::OP_PONG)
        else $error("data result with unknown opcode");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_data)
            && $stable(res_opcode) && $stable(res_frame_end))
        else $error("stalled result changed");

endmodule

bind websocket_client_frame_deframer_core wsdf_checker u_wsdf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_kind      (res.kind),
    .res_data      (res.data),
    .res_opcode    (res.opcode),
    .res_frame_end (res.frame_end)
);
